// ----- rtl/bft_pkg.sv -----
package bft_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Window geometry
  localparam int WIN      = 9;
  localparam int HALF     = 4;
  localparam int WIN_AREA = 81;
  localparam int LINES    = 8;
  localparam int LINE_SEL = $clog2(LINES);

  // Row counter and frame-geometry arithmetic width
  localparam int ROW_W = 13;

  // Register widths and reset values
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 12;
  localparam int THRESH_W     = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 11'd512;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 12'd512;
  localparam logic [THRESH_W-1:0]     THRESH_RST = 8'd121;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd2;

  // Result field widths
  localparam int MEAN_W    = 8;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 10;

  // Position and markers that travel with a result down the divide pipeline
  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
    logic                 frame_done;
  } res_tag_t;

endpackage

// ----- rtl/bft_if.sv -----
// Pixel request channel
interface bft_in_if #(parameter int PIXEL_BITS = bft_pkg::PIXEL_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, mode, pixel, input ready);
  modport sink   (input valid, mode, pixel, output ready);
endinterface

// Result request channel
interface bft_out_if;
  import bft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [MEAN_W-1:0]    mean;
  logic                 above_threshold;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 last_in_run;
  logic                 frame_done;

  modport source (output valid, mean, above_threshold, out_row, out_col, last_in_run,
                  frame_done, input ready);
  modport sink   (input valid, mean, above_threshold, out_row, out_col, last_in_run,
                  frame_done, output ready);
endinterface

// Register write channel
interface bft_cfg_if;
  import bft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/box_filter_threshold.sv -----
// Streaming 9x9 mean filter with threshold. Pixels arrive in raster order, one
// request per clock while in_chan.ready is high; each result carries the
// truncated mean of the zero-padded 9x9 window centred four rows and four
// columns behind the input, a bit that is set when that mean is above the
// threshold, the centre position, a marker on the last result of each input
// request and a marker on the frame's final result. After the image rows, send
// 4*image_width padding requests (mode 1) to drain. Throughput is one pixel per
// clock unless the output stalls or a row-end request that emits results steps
// the window unit five times (one per trailing centre). The eight previous rows
// live in one memory of MAX_WIDTH words, one word per column holding all eight
// rows, read and written back once per pixel. After reset a clearing pass zeroes
// that memory before the first pixel is taken; register writes are taken at any
// time, but should only be made while the block is idle. A pixel passes stage 1,
// the window unit, stages 3 and 4 and the output register to its result.
module box_filter_threshold #(
  parameter int MAX_WIDTH  = bft_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bft_pkg::PIXEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bft_in_if.sink        in_chan,
  bft_out_if.source     out_chan,
  bft_cfg_if.sink       cfg_chan
);
  import bft_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WORD_W = LINES * PIXEL_BITS;
  localparam int CSW    = PIXEL_BITS + 4;     // one column of nine samples
  localparam int SUM_W  = PIXEL_BITS + 7;     // whole window of 81 samples
  localparam int MK     = SUM_W + 7;          // reciprocal scale, exact below 2**SUM_W
  localparam int RW     = MK - 6;
  localparam int PW     = SUM_W + RW;
  localparam logic [RW-1:0] RECIP = RW'((2 ** MK + WIN_AREA - 1) / WIN_AREA);

  // ---------------------------------------------------------------------------
  // Registers
  logic [WIDTH_CFG_W-1:0]  width_cfg_r;
  logic [HEIGHT_CFG_W-1:0] height_cfg_r;
  logic [THRESH_W-1:0]     thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RST;
      height_cfg_r <= HEIGHT_RST;
      thresh_r     <= THRESH_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_WIDTH:  width_cfg_r  <= cfg_chan.data[WIDTH_CFG_W-1:0];
        REG_HEIGHT: height_cfg_r <= cfg_chan.data[HEIGHT_CFG_W-1:0];
        REG_THRESH: thresh_r     <= cfg_chan.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  // Clamped frame geometry
  logic [ROW_W-1:0] width_ext, w_eff, h_eff;

  always_comb begin
    width_ext = ROW_W'(width_cfg_r);
    if (width_ext < ROW_W'(HALF + 1))
      w_eff = ROW_W'(HALF + 1);
    else if (width_ext > ROW_W'(MAX_WIDTH))
      w_eff = ROW_W'(MAX_WIDTH);
    else
      w_eff = width_ext;
    h_eff = (height_cfg_r == '0) ? ROW_W'(1) : ROW_W'(height_cfg_r);
  end

  // ---------------------------------------------------------------------------
  // Line memory clearing pass after reset
  logic          clr_busy_r;
  logic [CW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CW'(MAX_WIDTH - 1))
        clr_busy_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input acceptance and position counters
  logic             in_ready, in_acc, s1_adv;
  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] col_ext;
  logic             row_end, frame_end;
  logic [PIXEL_BITS-1:0] pix_in;

  assign in_ready      = !clr_busy_r && (!s1_v_r || s1_adv);
  assign in_chan.ready = in_ready;
  assign in_acc        = in_chan.valid && in_ready;

  assign col_ext   = ROW_W'(col_r);
  assign row_end   = col_ext >= (w_eff - 1'b1);
  assign frame_end = row_end && (row_r >= h_eff + ROW_W'(3));
  assign pix_in    = (!in_chan.mode && row_r < h_eff) ? in_chan.pixel : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      if (frame_end) begin
        row_r <= '0;
        col_r <= '0;
      end else if (row_end) begin
        row_r <= row_r + 1'b1;
        col_r <= '0;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memory read data, column gather and write-back
  logic                  s1_v_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic [ROW_W-1:0]      s1_row_r;
  logic [CW-1:0]         s1_addr_r;
  logic                  s1_col0_r, s1_row_end_r, s1_frame_end_r, s1_emit_r;
  logic [ROW_W-1:0]      s1_colbase_r;
  logic [WORD_W-1:0]     rd_q_r;
  logic [WORD_W-1:0]     line_mem [MAX_WIDTH];

  logic [PIXEL_BITS-1:0] col_px [WIN];
  logic [WORD_W-1:0]     wr_word;
  logic [CSW-1:0]        colsum;
  logic                  s2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_v_r <= 1'b0;
    else if (in_acc)
      s1_v_r <= 1'b1;
    else if (s1_adv)
      s1_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r       <= pix_in;
      s1_row_r       <= row_r;
      s1_addr_r      <= col_r;
      s1_col0_r      <= (col_r == '0);
      s1_row_end_r   <= row_end;
      s1_frame_end_r <= frame_end;
      s1_emit_r      <= (row_r >= ROW_W'(HALF)) && (row_end || col_ext >= ROW_W'(HALF));
      s1_colbase_r   <= row_end ? (w_eff - ROW_W'(HALF + 1)) : (col_ext - ROW_W'(HALF));
    end
  end

  // Consecutive requests never share a column, so the pending write-back never
  // collides with the read of the next request.
  always_ff @(posedge clk) begin
    if (clr_busy_r)
      line_mem[clr_addr_r] <= '0;
    else if (s1_adv)
      line_mem[s1_addr_r] <= wr_word;
    if (in_acc)
      rd_q_r <= line_mem[col_r];
  end

  // Rows not yet seen in this frame read as zero
  always_comb begin
    logic [ROW_W-1:0] ridx;
    ridx = '0;
    for (int k = 0; k < LINES; k++) begin
      ridx = s1_row_r + ROW_W'(k);
      if (ridx >= ROW_W'(LINES))
        col_px[k] = rd_q_r[ridx[LINE_SEL-1:0] * PIXEL_BITS +: PIXEL_BITS];
      else
        col_px[k] = '0;
    end
    col_px[LINES] = s1_pix_r;
    colsum = '0;
    for (int k = 0; k < WIN; k++)
      colsum = colsum + CSW'(col_px[k]);
    for (int j = 0; j < LINES; j++)
      wr_word[j * PIXEL_BITS +: PIXEL_BITS] =
        (s1_row_r[LINE_SEL-1:0] == LINE_SEL'(j)) ? s1_pix_r
                                                  : rd_q_r[j * PIXEL_BITS +: PIXEL_BITS];
  end

  assign s1_adv = s1_v_r && s2_rdy;

  // ---------------------------------------------------------------------------
  // Stage 2: window unit, running column sums; a row end that emits results steps five times
  logic                 s2_v_r;
  logic [CSW-1:0]       s2_colsum_r;
  logic                 s2_col0_r, s2_row_end_r, s2_frame_end_r, s2_emit_r;
  logic [OUT_ROW_W-1:0] s2_orow_r;
  logic [ROW_W-1:0]     s2_colbase_r;
  logic [2:0]           step_r;
  logic [CSW-1:0]       taps_r [WIN];
  logic [SUM_W-1:0]     total_r;

  logic                 s2_last, step_go, s3_rdy, win_clear;
  logic [CSW-1:0]       newcol;
  logic [SUM_W-1:0]     total_nxt;
  logic [ROW_W-1:0]     ocol;

  assign s2_last   = !(s2_row_end_r && s2_emit_r) || (step_r == 3'(HALF));
  assign step_go   = s2_v_r && (!s2_emit_r || s3_rdy);
  assign s2_rdy    = !s2_v_r || (step_go && s2_last);
  assign newcol    = (step_r == '0) ? s2_colsum_r : '0;
  assign win_clear = (step_r == '0) && s2_col0_r;
  assign total_nxt = win_clear ? SUM_W'(newcol)
                               : total_r - SUM_W'(taps_r[0]) + SUM_W'(newcol);
  assign ocol      = s2_colbase_r + ROW_W'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (s1_adv)
        s2_v_r <= 1'b1;
      else if (step_go && s2_last)
        s2_v_r <= 1'b0;
      if (step_go)
        step_r <= s2_last ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_colsum_r    <= colsum;
      s2_col0_r      <= s1_col0_r;
      s2_row_end_r   <= s1_row_end_r;
      s2_frame_end_r <= s1_frame_end_r;
      s2_emit_r      <= s1_emit_r;
      s2_orow_r      <= OUT_ROW_W'(s1_row_r - ROW_W'(HALF));
      s2_colbase_r   <= s1_colbase_r;
    end
  end

  // Shift a column into the window; column zero starts from an empty window
  always_ff @(posedge clk) begin
    if (step_go) begin
      for (int j = 0; j < WIN - 1; j++)
        taps_r[j] <= win_clear ? '0 : taps_r[j + 1];
      taps_r[WIN - 1] <= newcol;
      total_r         <= total_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: divide by 81 through a reciprocal multiply
  logic             s3_v_r, s4_v_r, s3_load;
  logic [SUM_W-1:0] s3_sum_r;
  res_tag_t         s3_tag_r, s4_tag_r;
  logic [PW-1:0]    s4_prod_r;
  logic             s4_rdy, out_rdy;

  assign s3_load = step_go && s2_emit_r;
  assign s3_rdy  = !s3_v_r || s4_rdy;
  assign s4_rdy  = !s4_v_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_rdy)
        s3_v_r <= s3_load;
      if (s4_rdy)
        s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s3_load) begin
      s3_sum_r            <= total_nxt;
      s3_tag_r.row        <= s2_orow_r;
      s3_tag_r.col        <= ocol[OUT_COL_W-1:0];
      s3_tag_r.last       <= s2_last;
      s3_tag_r.frame_done <= s2_frame_end_r && s2_last;
    end
    if (s4_rdy && s3_v_r) begin
      s4_prod_r <= PW'(s3_sum_r) * PW'(RECIP);
      s4_tag_r  <= s3_tag_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: saturate, compare against threshold
  logic                  out_v_r;
  logic [MEAN_W-1:0]     out_mean_r;
  logic                  out_above_r;
  res_tag_t              out_tag_r;
  logic [PIXEL_BITS-1:0] quot;

  assign out_rdy = !out_v_r || out_chan.ready;
  assign quot    = s4_prod_r[MK +: PIXEL_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_v_r <= 1'b0;
    else if (out_rdy)
      out_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s4_v_r) begin
      out_mean_r  <= (quot > PIXEL_BITS'(255)) ? 8'hFF : quot[MEAN_W-1:0];
      out_above_r <= quot > PIXEL_BITS'(thresh_r);
      out_tag_r   <= s4_tag_r;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.mean            = out_mean_r;
  assign out_chan.above_threshold = out_above_r;
  assign out_chan.out_row         = out_tag_r.row;
  assign out_chan.out_col         = out_tag_r.col;
  assign out_chan.last_in_run     = out_tag_r.last;
  assign out_chan.frame_done      = out_tag_r.frame_done;

endmodule
